// ----- rtl/rc5_pkg.sv -----
// ----------------------------------------------------------------------------
// RC5 package
// Shared constants, opcodes, register indexes, rotate helpers and the
// control struct passed from the top level to the round datapath.
// ----------------------------------------------------------------------------
package rc5_pkg;

   // Word size and default cipher geometry
   localparam int RC5_WORD_W          = 16;
   localparam int RC5_ROUNDS          = 12;
   localparam int RC5_KEY_BYTES       = 16;
   localparam int RC5_KEY_STORE_DEPTH = 8;
   localparam int RC5_KEY_ADDR_W      = $clog2(RC5_KEY_STORE_DEPTH);
   localparam int RC5_KEY_BITS        = 128;
   localparam int RC5_CSR_W           = 64;

   // Key schedule magic constants
   localparam logic [RC5_WORD_W-1:0] RC5_MAGIC_P = 16'hb7e1;
   localparam logic [RC5_WORD_W-1:0] RC5_MAGIC_Q = 16'h9e37;

   // Opcodes carried in tuser
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // Configuration register indexes
   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   // Control from the top level to the round datapath
   typedef struct packed {
      logic start;     // begin a block using the latched payload
      logic decrypt;   // direction of the block
      logic res_take;  // finished result has been moved to the output stage
   } rc5_cmd_type;

   // Rotate left by the low four bits of the amount
   function automatic logic [RC5_WORD_W-1:0] rc5_rotl(input logic [RC5_WORD_W-1:0] x,
                                                     input logic [3:0] s);
      logic [2*RC5_WORD_W-1:0] d;
      d = {x, x} << s;
      return d[2*RC5_WORD_W-1:RC5_WORD_W];
   endfunction

   // Rotate right by the low four bits of the amount
   function automatic logic [RC5_WORD_W-1:0] rc5_rotr(input logic [RC5_WORD_W-1:0] x,
                                                     input logic [3:0] s);
      logic [2*RC5_WORD_W-1:0] d;
      d = {x, x} >> s;
      return d[RC5_WORD_W-1:0];
   endfunction

endpackage

// ----- rtl/rc5_ram.sv -----
// ----------------------------------------------------------------------------
// RC5 generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rc5_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rc5_sched.sv -----
// ----------------------------------------------------------------------------
// RC5 key schedule sequencer
// Seeds the subkey banks and the key word store, then runs the mixing
// steps as read / update A / update B over the two memories.
// ----------------------------------------------------------------------------
module rc5_sched #(
   parameter int ROUNDS    = rc5_pkg::RC5_ROUNDS,
   parameter int KEY_BYTES = rc5_pkg::RC5_KEY_BYTES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rc5_pkg::RC5_CSR_W-1:0]      key_low,
   input  logic [rc5_pkg::RC5_CSR_W-1:0]      key_high,
   output logic [$clog2(ROUNDS+1)-1:0]        s_addr,
   output logic                               s_wr_even,
   output logic                               s_wr_odd,
   output logic [rc5_pkg::RC5_WORD_W-1:0]     s_wr_data,
   input  logic [rc5_pkg::RC5_WORD_W-1:0]     even_rdata,
   input  logic [rc5_pkg::RC5_WORD_W-1:0]     odd_rdata,
   output logic [rc5_pkg::RC5_KEY_ADDR_W-1:0] key_addr,
   output logic                               key_wr_en,
   output logic [rc5_pkg::RC5_WORD_W-1:0]     key_wr_data,
   input  logic [rc5_pkg::RC5_WORD_W-1:0]     key_rdata,
   output logic                               done
);
   import rc5_pkg::*;

   localparam int SUB_WORDS = 2 * ROUNDS + 2;
   localparam int KEY_WORDS = (KEY_BYTES + 1) / 2;
   localparam int INIT_N    = (SUB_WORDS > KEY_WORDS) ? SUB_WORDS : KEY_WORDS;
   localparam int STEPS     = 3 * INIT_N;
   localparam int SI_W      = $clog2(SUB_WORDS);
   localparam int STEP_W    = $clog2(STEPS);
   localparam logic [RC5_KEY_BITS-1:0] KEY_MASK =
      {RC5_KEY_BITS{1'b1}} >> (RC5_KEY_BITS - 8 * KEY_BYTES);

   localparam logic [2:0] SC_IDLE = 3'd0;
   localparam logic [2:0] SC_INIT = 3'd1;
   localparam logic [2:0] SC_READ = 3'd2;
   localparam logic [2:0] SC_MIXA = 3'd3;
   localparam logic [2:0] SC_MIXB = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [SI_W-1:0]           si_ff, si_in;
   logic [RC5_KEY_ADDR_W-1:0] ki_ff, ki_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [RC5_WORD_W-1:0]     acc_ff, acc_in;
   logic [RC5_WORD_W-1:0]     a_ff, a_in;
   logic [RC5_WORD_W-1:0]     b_ff, b_in;

   logic [RC5_KEY_BITS-1:0]   key_all;
   logic [RC5_WORD_W-1:0]     key_word;
   logic [RC5_WORD_W-1:0]     s_rdata;
   logic [RC5_WORD_W-1:0]     ab_sum;
   logic [RC5_WORD_W-1:0]     a_sum;
   logic [RC5_WORD_W-1:0]     b_sum;
   logic [RC5_WORD_W-1:0]     a_mix;
   logic [RC5_WORD_W-1:0]     b_mix;
   logic                      s_wr;
   logic                      init_last;
   logic                      mix_last;
   logic [SI_W-1:0]           si_next;
   logic [RC5_KEY_ADDR_W-1:0] ki_next;

   // Pick the key word for the initial fill, unused bytes read as zero
   assign key_all  = {key_high, key_low} & KEY_MASK;
   assign key_word = key_all[{ki_ff, 4'b0000} +: RC5_WORD_W];

   // Mixing arithmetic
   assign s_rdata = si_ff[0] ? odd_rdata : even_rdata;
   assign ab_sum  = a_ff + b_ff;
   assign a_sum   = s_rdata + ab_sum;
   assign b_sum   = key_rdata + ab_sum;
   assign a_mix   = rc5_rotl(a_sum, 4'd3);
   assign b_mix   = rc5_rotl(b_sum, ab_sum[3:0]);

   assign init_last = (step_ff == STEP_W'(INIT_N - 1));
   assign mix_last  = (step_ff == STEP_W'(STEPS - 1));
   assign si_next   = (si_ff == SI_W'(SUB_WORDS - 1)) ? '0 : si_ff + 1'b1;
   assign ki_next   = (ki_ff == RC5_KEY_ADDR_W'(KEY_WORDS - 1)) ? '0 : ki_ff + 1'b1;

   // Memory ports
   assign s_wr        = ((state_ff == SC_INIT) && (step_ff < STEP_W'(SUB_WORDS))) ||
                        (state_ff == SC_MIXA);
   assign s_addr      = si_ff[SI_W-1:1];
   assign s_wr_even   = s_wr && !si_ff[0];
   assign s_wr_odd    = s_wr && si_ff[0];
   assign s_wr_data   = (state_ff == SC_INIT) ? acc_ff : a_mix;
   assign key_addr    = ki_ff;
   assign key_wr_en   = ((state_ff == SC_INIT) && (step_ff < STEP_W'(KEY_WORDS))) ||
                        (state_ff == SC_MIXB);
   assign key_wr_data = (state_ff == SC_INIT) ? key_word : b_mix;
   assign done        = (state_ff == SC_MIXB) && mix_last;

   // Sequence the fill and the mixing steps
   always_comb begin
      state_in = state_ff;
      si_in    = si_ff;
      ki_in    = ki_ff;
      step_in  = step_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               state_in = SC_INIT;
               si_in    = '0;
               ki_in    = '0;
               step_in  = '0;
               acc_in   = RC5_MAGIC_P;
            end
         end
         SC_INIT: begin
            acc_in = acc_ff + RC5_MAGIC_Q;
            if (init_last) begin
               state_in = SC_READ;
               si_in    = '0;
               ki_in    = '0;
               step_in  = '0;
               a_in     = '0;
               b_in     = '0;
            end else begin
               si_in   = si_next;
               ki_in   = ki_next;
               step_in = step_ff + 1'b1;
            end
         end
         SC_READ: begin
            state_in = SC_MIXA;
         end
         SC_MIXA: begin
            a_in     = a_mix;
            state_in = SC_MIXB;
         end
         SC_MIXB: begin
            b_in    = b_mix;
            si_in   = si_next;
            ki_in   = ki_next;
            step_in = step_ff + 1'b1;
            state_in = mix_last ? SC_IDLE : SC_READ;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   // Hold control state, payload registers carry no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff   <= si_in;
      ki_ff   <= ki_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
   end

endmodule

// ----- rtl/rc5_core.sv -----
// ----------------------------------------------------------------------------
// RC5 round datapath
// One full round per cycle, subkeys streamed from the even and odd banks
// one address ahead of the data.
// ----------------------------------------------------------------------------
module rc5_core #(
   parameter int ROUNDS = rc5_pkg::RC5_ROUNDS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rc5_pkg::rc5_cmd_type           cmd,
   input  logic [rc5_pkg::RC5_WORD_W-1:0] in_a,
   input  logic [rc5_pkg::RC5_WORD_W-1:0] in_b,
   input  logic [rc5_pkg::RC5_WORD_W-1:0] key_even,
   input  logic [rc5_pkg::RC5_WORD_W-1:0] key_odd,
   output logic [$clog2(ROUNDS+1)-1:0]    rd_addr,
   output logic                           res_valid,
   output logic [rc5_pkg::RC5_WORD_W-1:0] out_a,
   output logic [rc5_pkg::RC5_WORD_W-1:0] out_b
);
   import rc5_pkg::*;

   localparam int BA_W = $clog2(ROUNDS + 1);

   localparam logic [1:0] CS_IDLE = 2'd0;
   localparam logic [1:0] CS_WAIT = 2'd1;
   localparam logic [1:0] CS_RUN  = 2'd2;
   localparam logic [1:0] CS_DONE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic                  dec_ff, dec_in;
   logic [BA_W-1:0]       cnt_ff, cnt_in;
   logic [BA_W-1:0]       addr_ff, addr_in;
   logic [RC5_WORD_W-1:0] a_ff, a_in;
   logic [RC5_WORD_W-1:0] b_ff, b_in;

   logic                  first;
   logic                  last;
   logic                  addr_step;
   logic [BA_W-1:0]       addr_next;
   logic [RC5_WORD_W-1:0] enc_a, enc_b;
   logic [RC5_WORD_W-1:0] dec_a, dec_b;
   logic [RC5_WORD_W-1:0] rnd_a, rnd_b;

   assign first     = (cnt_ff == '0);
   assign last      = (cnt_ff == BA_W'(ROUNDS));
   assign addr_step = (cnt_ff < BA_W'(ROUNDS - 1));
   assign addr_next = dec_ff ? addr_ff - 1'b1 : addr_ff + 1'b1;

   // Encrypt: whiten on the first data cycle, a round otherwise
   always_comb begin
      if (first) begin
         enc_a = a_ff + key_even;
         enc_b = b_ff + key_odd;
      end else begin
         enc_a = rc5_rotl(a_ff ^ b_ff, b_ff[3:0]) + key_even;
         enc_b = rc5_rotl(b_ff ^ enc_a, enc_a[3:0]) + key_odd;
      end
   end

   // Decrypt: inverse round, then remove the whitening on the last cycle
   always_comb begin
      if (last) begin
         dec_b = b_ff - key_odd;
         dec_a = a_ff - key_even;
      end else begin
         dec_b = rc5_rotr(b_ff - key_odd, a_ff[3:0]) ^ a_ff;
         dec_a = rc5_rotr(a_ff - key_even, dec_b[3:0]) ^ dec_b;
      end
   end

   assign rnd_a = dec_ff ? dec_a : enc_a;
   assign rnd_b = dec_ff ? dec_b : enc_b;

   // Sequence one block
   always_comb begin
      state_in = state_ff;
      dec_in   = dec_ff;
      cnt_in   = cnt_ff;
      addr_in  = addr_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (cmd.start) begin
               state_in = CS_WAIT;
               dec_in   = cmd.decrypt;
               cnt_in   = '0;
               addr_in  = (cmd.decrypt == OP_DECRYPT) ? BA_W'(ROUNDS) : '0;
               a_in     = in_a;
               b_in     = in_b;
            end
         end
         CS_WAIT: begin
            addr_in  = addr_next;
            state_in = CS_RUN;
         end
         CS_RUN: begin
            a_in = rnd_a;
            b_in = rnd_b;
            if (last) begin
               state_in = CS_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (addr_step) begin
                  addr_in = addr_next;
               end
            end
         end
         CS_DONE: begin
            if (cmd.res_take) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff  <= dec_in;
      cnt_ff  <= cnt_in;
      addr_ff <= addr_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
   end

   assign rd_addr   = addr_ff;
   assign res_valid = (state_ff == CS_DONE);
   assign out_a     = a_ff;
   assign out_b     = b_ff;

endmodule

// ----- rtl/rc5_16_block_cipher_top.sv -----
// ----------------------------------------------------------------------------
// RC5-16 block cipher top level
// Stream channels for blocks in and results out, key registers, subkey
// memories (even and odd banks) and the key word store.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : key_low (index 0) and key_high (index 1), 64 bits each. Write
//            only while idle; any key write forces a fresh key expansion.
//   req_*  : one block per transaction, tdata = {in_b, in_a}, tuser = opcode
//            (0 encrypt, 1 decrypt).
//   rsp_*  : one result per block, tdata = {out_b, out_a}.
// An accepted block passes the GO state and the datapath's wait and run
//   states, then its result moves to the output register; a new block is
//   taken only after that move. The round datapath does one full round
//   per cycle, fed by the two subkey banks read in parallel.
// The first block after reset or a key write first runs the key schedule:
//   a fill over the subkeys or key words, whichever are more, then the
//   mixing steps, each a read, an update of A and an update of B.
// Reset clears the channels and marks the schedule as not run; memories
//   are not cleared, they are always written before they are read.
// A stalled rsp_tready holds the result in the output register; the next
//   block is still accepted and runs up to its own result, then waits.
// ----------------------------------------------------------------------------
module rc5_16_block_cipher_top #(
   parameter int ROUNDS    = rc5_pkg::RC5_ROUNDS,
   parameter int KEY_BYTES = rc5_pkg::RC5_KEY_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [rc5_pkg::RC5_CSR_W-1:0] csr_data,
   // Block input channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,   // in_a [15:0], in_b [31:16]
   input  logic                          req_tuser,   // opcode [0]
   // Result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata    // out_a [15:0], out_b [31:16]
);
   import rc5_pkg::*;

   localparam int BANK_DEPTH = ROUNDS + 1;
   localparam int BA_W       = $clog2(BANK_DEPTH);

   localparam logic [1:0] TS_IDLE  = 2'd0;
   localparam logic [1:0] TS_SCHED = 2'd1;
   localparam logic [1:0] TS_GO    = 2'd2;
   localparam logic [1:0] TS_RUN   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic                  ready_ff, ready_in;
   logic [RC5_CSR_W-1:0]  key_low_ff, key_low_in;
   logic [RC5_CSR_W-1:0]  key_high_ff, key_high_in;
   logic                  op_ff;
   logic [RC5_WORD_W-1:0] blk_a_ff;
   logic [RC5_WORD_W-1:0] blk_b_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff;

   logic                  req_fire;
   logic                  csr_fire;
   logic                  out_free;
   logic                  res_move;
   rc5_cmd_type           cmd;

   // Scheduler and memory wiring
   logic                      sched_start;
   logic                      sched_done;
   logic [BA_W-1:0]           sched_s_addr;
   logic                      s_wr_even;
   logic                      s_wr_odd;
   logic [RC5_WORD_W-1:0]     s_wr_data;
   logic [RC5_KEY_ADDR_W-1:0] key_addr;
   logic                      key_wr_en;
   logic [RC5_WORD_W-1:0]     key_wr_data;
   logic [RC5_WORD_W-1:0]     even_rdata;
   logic [RC5_WORD_W-1:0]     odd_rdata;
   logic [RC5_WORD_W-1:0]     key_rdata;
   logic [BA_W-1:0]           core_addr;
   logic [BA_W-1:0]           bank_rd_addr;
   logic                      core_valid;
   logic [RC5_WORD_W-1:0]     core_a;
   logic [RC5_WORD_W-1:0]     core_b;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = (state_ff == TS_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign res_move   = (state_ff == TS_RUN) && core_valid && out_free;

   assign sched_start = req_fire && !ready_ff;
   assign cmd.start    = (state_ff == TS_GO);
   assign cmd.decrypt  = op_ff;
   assign cmd.res_take = res_move;

   // Key registers and schedule status
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      ready_in    = ready_ff;
      if (sched_done) begin
         ready_in = 1'b1;
      end
      if (csr_fire) begin
         unique case (csr_index)
            CSR_KEY_LOW: begin
               key_low_in = csr_data;
               ready_in   = 1'b0;
            end
            CSR_KEY_HIGH: begin
               key_high_in = csr_data;
               ready_in    = 1'b0;
            end
            default: begin
               ready_in = ready_ff;
            end
         endcase
      end
   end

   // Block sequencing
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TS_IDLE: begin
            if (req_fire) begin
               state_in = ready_ff ? TS_GO : TS_SCHED;
            end
         end
         TS_SCHED: begin
            if (sched_done) begin
               state_in = TS_GO;
            end
         end
         TS_GO: begin
            state_in = TS_RUN;
         end
         TS_RUN: begin
            if (res_move) begin
               state_in = TS_IDLE;
            end
         end
         default: begin
            state_in = TS_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TS_IDLE;
         ready_ff     <= 1'b0;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         key_low_ff   <= key_low_in;
         key_high_ff  <= key_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the block payload and the result
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_tuser;
         blk_a_ff <= req_tdata[15:0];
         blk_b_ff <= req_tdata[31:16];
      end
      if (res_move) begin
         rsp_data_ff <= {core_b, core_a};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Subkey banks are shared: scheduler while it runs, datapath otherwise
   assign bank_rd_addr = (state_ff == TS_SCHED) ? sched_s_addr : core_addr;

   rc5_sched #(
      .ROUNDS    (ROUNDS),
      .KEY_BYTES (KEY_BYTES)
   ) u_sched (
      .clock       (clock),
      .reset       (reset),
      .start       (sched_start),
      .key_low     (key_low_ff),
      .key_high    (key_high_ff),
      .s_addr      (sched_s_addr),
      .s_wr_even   (s_wr_even),
      .s_wr_odd    (s_wr_odd),
      .s_wr_data   (s_wr_data),
      .even_rdata  (even_rdata),
      .odd_rdata   (odd_rdata),
      .key_addr    (key_addr),
      .key_wr_en   (key_wr_en),
      .key_wr_data (key_wr_data),
      .key_rdata   (key_rdata),
      .done        (sched_done)
   );

   rc5_ram #(
      .WIDTH (RC5_WORD_W),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (s_wr_even),
      .wr_addr (sched_s_addr),
      .wr_data (s_wr_data),
      .rd_addr (bank_rd_addr),
      .rd_data (even_rdata)
   );

   rc5_ram #(
      .WIDTH (RC5_WORD_W),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (s_wr_odd),
      .wr_addr (sched_s_addr),
      .wr_data (s_wr_data),
      .rd_addr (bank_rd_addr),
      .rd_data (odd_rdata)
   );

   rc5_ram #(
      .WIDTH (RC5_WORD_W),
      .DEPTH (RC5_KEY_STORE_DEPTH)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_addr),
      .wr_data (key_wr_data),
      .rd_addr (key_addr),
      .rd_data (key_rdata)
   );

   rc5_core #(
      .ROUNDS (ROUNDS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_a      (blk_a_ff),
      .in_b      (blk_b_ff),
      .key_even  (even_rdata),
      .key_odd   (odd_rdata),
      .rd_addr   (core_addr),
      .res_valid (core_valid),
      .out_a     (core_a),
      .out_b     (core_b)
   );

endmodule

// ----- rtl/rc5_checker.sv -----
// ----------------------------------------------------------------------------
// RC5 port checker
// Watches the top level's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module rc5_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic req_fire;
   logic csr_fire;

   assign req_fire = req_tvalid && req_tready;
   assign csr_fire = csr_valid && csr_ready;

   // Drop the result channel on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // One block in flight: no second transaction right behind the first
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("block accepted while another is in flight");

   // A result never appears in the cycle right after a block is taken
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !$rose(rsp_tvalid))
      else $error("result raised too early after a block transaction");

   // Configuration is never written in the cycle a block is taken
   a_csr_apart: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !csr_fire)
      else $error("configuration written together with a block transaction");

endmodule

bind rc5_16_block_cipher_top rc5_checker u_checker (.*);
